### hw/rtl/trdm_pkg.sv
// Shared types and constants of the transmit descriptor ring manager.
`timescale 1ns / 1ps
package trdm_pkg;

    localparam int RING_DEPTH = 64;
    localparam int IDX_W      = $clog2(RING_DEPTH);
    localparam int LEN_W      = 16;
    localparam int CNT_W      = 7;
    localparam int OCC_W      = IDX_W + 2;
    localparam int TOT_W      = 32;
    localparam int REC_W      = 6;

    localparam logic [31:0] CMD_FCS        = 32'h0002_0000;
    localparam logic [31:0] CMD_FS         = 32'h2000_0000;
    localparam logic [31:0] CMD_LS         = 32'h1000_0000;
    localparam logic [31:0] CMD_IOC        = 32'h0400_0000;
    localparam logic [31:0] CMD_DTYPE_DATA = 32'h0000_0000;

    localparam logic MODE_FRAG  = 1'b0;
    localparam logic MODE_COMPL = 1'b1;

    typedef enum logic [1:0] {
        ST_WRITTEN = 2'd0,
        ST_DROPPED = 2'd1,
        ST_COMPL   = 2'd2
    } status_t;

    typedef enum logic {
        BK_IDLE,
        BK_WALK
    } back_state_t;

    // One decoded request as it sits in the queue between front and back.
    typedef struct packed {
        logic               is_compl;
        logic [LEN_W-1:0]   length;
        logic               sop;
        logic               eop;
        logic               start;
        logic [CNT_W-1:0]   count;
        logic [IDX_W-1:0]   head;
    } desc_cmd_t;

endpackage

### hw/rtl/trdm_front.sv
// Front part: accepts requests, decodes them and buffers them in a two-entry queue.
`timescale 1ns / 1ps
module trdm_front
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     mode,
    input  logic [15:0]              frag_length,
    input  logic                     sop_flag,
    input  logic                     eop_flag,
    input  logic                     send_start,
    input  logic [6:0]               send_fragments,
    input  logic [5:0]               head_index,
    output logic                     q_valid,
    input  logic                     q_pop,
    output trdm_pkg::desc_cmd_t      q_item
);
    import trdm_pkg::*;

    desc_cmd_t  entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;
    desc_cmd_t  decoded;

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign pop      = q_pop && q_valid;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = entry_reg[rd_ptr_reg];

    // A fragment count is only meaningful with a send start; zero counts as one.
    always_comb
    begin
        decoded          = '0;
        decoded.is_compl = (mode == MODE_COMPL);
        decoded.length   = frag_length;
        decoded.sop      = sop_flag;
        decoded.eop      = eop_flag;
        decoded.start    = send_start;
        decoded.count    = (send_start && (send_fragments != '0)) ?
                           send_fragments : CNT_W'(1);
        decoded.head     = head_index[IDX_W-1:0];
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

### hw/rtl/trdm_back.sv
// Back part: ring state, slot length memory, completion walk and result register.
`timescale 1ns / 1ps
module trdm_back
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_valid,
    output logic                     q_pop,
    input  trdm_pkg::desc_cmd_t      q_item,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [1:0]               status,
    output logic [5:0]               desc_index,
    output logic [31:0]              cmd_word,
    output logic [31:0]              length_word,
    output logic                     tail_update,
    output logic [5:0]               tail_index,
    output logic [5:0]               reclaimed,
    output logic [31:0]              byte_total,
    output logic [31:0]              desc_total,
    output logic [31:0]              drop_total
);
    import trdm_pkg::*;

    back_state_t        state_reg;
    back_state_t        state_next;

    logic [IDX_W-1:0]   write_index_reg;
    logic [IDX_W-1:0]   write_index_next;
    logic [IDX_W-1:0]   read_index_reg;
    logic [IDX_W-1:0]   read_index_next;
    logic [IDX_W-1:0]   target_reg;
    logic [IDX_W-1:0]   target_next;
    logic [REC_W-1:0]   rec_cnt_reg;
    logic [REC_W-1:0]   rec_cnt_next;
    logic [TOT_W-1:0]   bytes_sent_reg;
    logic [TOT_W-1:0]   bytes_sent_next;
    logic [TOT_W-1:0]   descs_done_reg;
    logic [TOT_W-1:0]   descs_done_next;
    logic [TOT_W-1:0]   sends_dropped_reg;
    logic [TOT_W-1:0]   sends_dropped_next;
    logic [CNT_W-1:0]   frags_left_reg;
    logic [CNT_W-1:0]   frags_left_next;
    logic               dropping_reg;
    logic               dropping_next;
    logic               out_valid_reg;
    logic               out_valid_next;

    status_t            status_reg;
    logic [IDX_W-1:0]   desc_index_reg;
    logic [31:0]        cmd_word_reg;
    logic [31:0]        length_word_reg;
    logic               tail_update_reg;
    logic [IDX_W-1:0]   tail_index_reg;
    logic [REC_W-1:0]   reclaimed_reg;
    logic [TOT_W-1:0]   byte_total_reg;
    logic [TOT_W-1:0]   desc_total_reg;
    logic [TOT_W-1:0]   drop_total_reg;

    logic [LEN_W-1:0]   slot_len_mem [RING_DEPTH];
    logic [LEN_W-1:0]   slot_rd_reg;

    logic               out_free;
    logic               frag_do;
    logic               walk_start;
    logic               walk_step;
    logic               walk_done;
    logic               new_send;
    logic [IDX_W-1:0]   occupancy;
    logic               drop_new;
    logic               drop_eff;
    logic [CNT_W-1:0]   frags_base;
    logic [CNT_W-1:0]   frags_after;
    logic [IDX_W-1:0]   write_index_inc;
    logic               mem_we;
    logic [31:0]        cmd_calc;

    assign out_free = !out_valid_reg || !out_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && q_item.is_compl)
                begin
                    state_next = BK_WALK;
                end
            end
            BK_WALK:
            begin
                if ((read_index_reg == target_reg) && out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        q_pop      = 1'b0;
        frag_do    = 1'b0;
        walk_start = 1'b0;
        walk_step  = 1'b0;
        walk_done  = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                walk_start = q_valid && q_item.is_compl;
                frag_do    = q_valid && !q_item.is_compl && out_free;
                q_pop      = walk_start || frag_do;
            end
            BK_WALK:
            begin
                walk_step = (read_index_reg != target_reg);
                walk_done = (read_index_reg == target_reg) && out_free;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // Fragment classification against the current ring occupancy.
    always_comb
    begin
        new_send        = q_item.start || (frags_left_reg == '0);
        occupancy       = write_index_reg - read_index_reg;
        drop_new        = ({2'b00, occupancy} + {1'b0, q_item.count}) >= OCC_W'(RING_DEPTH);
        drop_eff        = new_send ? drop_new : dropping_reg;
        frags_base      = new_send ? q_item.count : frags_left_reg;
        frags_after     = frags_base - CNT_W'(1);
        write_index_inc = write_index_reg + IDX_W'(1);
        mem_we          = frag_do && !drop_eff;
        cmd_calc        = {16'h0000, q_item.length} | CMD_DTYPE_DATA | CMD_FCS;
        if (q_item.sop)
        begin
            cmd_calc = cmd_calc | CMD_FS;
        end
        if (q_item.eop)
        begin
            cmd_calc = cmd_calc | CMD_IOC | CMD_LS;
        end
    end

    always_comb
    begin
        write_index_next   = write_index_reg;
        read_index_next    = read_index_reg;
        target_next        = target_reg;
        rec_cnt_next       = rec_cnt_reg;
        bytes_sent_next    = bytes_sent_reg;
        descs_done_next    = descs_done_reg;
        sends_dropped_next = sends_dropped_reg;
        frags_left_next    = frags_left_reg;
        dropping_next      = dropping_reg;
        out_valid_next     = out_valid_reg && out_stall;

        if (frag_do)
        begin
            frags_left_next = frags_after;
            dropping_next   = drop_eff;
            if (new_send && drop_new)
            begin
                sends_dropped_next = sends_dropped_reg + TOT_W'(1);
            end
            if (!drop_eff)
            begin
                write_index_next = write_index_inc;
            end
            out_valid_next = 1'b1;
        end

        if (walk_start)
        begin
            target_next  = q_item.head;
            rec_cnt_next = '0;
        end

        if (walk_step)
        begin
            bytes_sent_next = bytes_sent_reg + {{(TOT_W-LEN_W){1'b0}}, slot_rd_reg};
            descs_done_next = descs_done_reg + TOT_W'(1);
            read_index_next = read_index_reg + IDX_W'(1);
            rec_cnt_next    = (rec_cnt_reg == '1) ? rec_cnt_reg : rec_cnt_reg + REC_W'(1);
        end

        if (walk_done)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= BK_IDLE;
            write_index_reg   <= '0;
            read_index_reg    <= '0;
            target_reg        <= '0;
            rec_cnt_reg       <= '0;
            bytes_sent_reg    <= '0;
            descs_done_reg    <= '0;
            sends_dropped_reg <= '0;
            frags_left_reg    <= '0;
            dropping_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            write_index_reg   <= write_index_next;
            read_index_reg    <= read_index_next;
            target_reg        <= target_next;
            rec_cnt_reg       <= rec_cnt_next;
            bytes_sent_reg    <= bytes_sent_next;
            descs_done_reg    <= descs_done_next;
            sends_dropped_reg <= sends_dropped_next;
            frags_left_reg    <= frags_left_next;
            dropping_reg      <= dropping_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (frag_do)
        begin
            status_reg      <= drop_eff ? ST_DROPPED : ST_WRITTEN;
            desc_index_reg  <= drop_eff ? '0 : write_index_reg;
            cmd_word_reg    <= drop_eff ? '0 : cmd_calc;
            length_word_reg <= drop_eff ? '0 : {q_item.length, 16'h0000};
            tail_update_reg <= !drop_eff && (frags_after == '0);
            tail_index_reg  <= (!drop_eff && (frags_after == '0)) ? write_index_inc : '0;
            reclaimed_reg   <= '0;
            byte_total_reg  <= bytes_sent_reg;
            desc_total_reg  <= descs_done_reg;
            drop_total_reg  <= sends_dropped_next;
        end
        else if (walk_done)
        begin
            status_reg      <= ST_COMPL;
            desc_index_reg  <= '0;
            cmd_word_reg    <= '0;
            length_word_reg <= '0;
            tail_update_reg <= 1'b0;
            tail_index_reg  <= '0;
            reclaimed_reg   <= rec_cnt_reg;
            byte_total_reg  <= bytes_sent_reg;
            desc_total_reg  <= descs_done_reg;
            drop_total_reg  <= sends_dropped_reg;
        end
    end

    // Slot lengths. The read port follows the next read index so the length of the
    // slot at the current read index is always on hand; a write to that same slot
    // is forwarded.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_len_mem[write_index_reg] <= q_item.length;
        end
        if (mem_we && (write_index_reg == read_index_next))
        begin
            slot_rd_reg <= q_item.length;
        end
        else
        begin
            slot_rd_reg <= slot_len_mem[read_index_next];
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign desc_index  = desc_index_reg;
    assign cmd_word    = cmd_word_reg;
    assign length_word = length_word_reg;
    assign tail_update = tail_update_reg;
    assign tail_index  = tail_index_reg;
    assign reclaimed   = reclaimed_reg;
    assign byte_total  = byte_total_reg;
    assign desc_total  = desc_total_reg;
    assign drop_total  = drop_total_reg;

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == BK_IDLE) && q_valid)
        else $error("queue popped outside idle state");

    a_walk_advance: assert property (@(posedge clk) disable iff (!rst_n)
        walk_step |=> (read_index_reg == $past(read_index_reg) + IDX_W'(1))
                      && (descs_done_reg == $past(descs_done_reg) + TOT_W'(1)))
        else $error("completion walk did not advance by one slot");

    a_drop_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (frag_do && drop_eff) |=> $stable(write_index_reg))
        else $error("dropped fragment moved the write index");

    a_walk_no_frag: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_WALK) |-> !frag_do && !mem_we)
        else $error("fragment handled during a completion walk");

    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        (frag_do || walk_done) |-> out_free)
        else $error("result loaded over an untaken result");

endmodule

### hw/rtl/tx_descriptor_ring_manager.sv
// Top level of the transmit descriptor ring manager.
`timescale 1ns / 1ps
// With the queue empty and the back part idle, a fragment's transfer is written into the front
// queue and from there into the result register, unless a stalled result holds it.
// The back part takes one fragment per cycle while no completion walk runs and the result side
// does not stall; the walk reads one slot length per cycle over the N descriptors reclaimed.
// Reset is asynchronous and active low: indices, counters, send tracking, queue and
// result valid clear at once; the slot length memory is not cleared.
module tx_descriptor_ring_manager
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [15:0] frag_length,
    input  logic        sop_flag,
    input  logic        eop_flag,
    input  logic        send_start,
    input  logic [6:0]  send_fragments,
    input  logic [5:0]  head_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [5:0]  desc_index,
    output logic [31:0] cmd_word,
    output logic [31:0] length_word,
    output logic        tail_update,
    output logic [5:0]  tail_index,
    output logic [5:0]  reclaimed,
    output logic [31:0] byte_total,
    output logic [31:0] desc_total,
    output logic [31:0] drop_total
);
    import trdm_pkg::*;

    // The front part takes each transfer, decodes it into a fragment or completion
    // request and holds it in a two-entry queue, so up to two input transfers are taken
    // while the back part is busy walking the ring or waiting on a stalled result.
    desc_cmd_t q_item;
    logic      q_valid;
    logic      q_pop;

    trdm_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .frag_length    (frag_length),
        .sop_flag       (sop_flag),
        .eop_flag       (eop_flag),
        .send_start     (send_start),
        .send_fragments (send_fragments),
        .head_index     (head_index),
        .q_valid        (q_valid),
        .q_pop          (q_pop),
        .q_item         (q_item)
    );

    // The back part owns the ring indices, the per-slot lengths and the counters.
    // A fragment is classified against the current occupancy (a whole send is
    // dropped when it would fill the ring), written and reported in the same cycle.
    // A completion walks the read index to the head, one slot per cycle, and then
    // reports the number reclaimed. Results sit in an output register that the
    // consumer drains through out_valid and out_stall.
    trdm_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_item      (q_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .desc_index  (desc_index),
        .cmd_word    (cmd_word),
        .length_word (length_word),
        .tail_update (tail_update),
        .tail_index  (tail_index),
        .reclaimed   (reclaimed),
        .byte_total  (byte_total),
        .desc_total  (desc_total),
        .drop_total  (drop_total)
    );

endmodule

### sim/tb_top.sv
// Self-checking testbench for the transmit descriptor ring manager.
`timescale 1ns / 1ps
// The testbench drives fragment and completion transfers into the ring manager.
// It keeps its own shadow of the ring: indices, slot lengths, counters and send
// tracking. From that shadow it predicts one result for every accepted transfer.
// Each result that leaves the block is compared field by field with the oldest
// prediction.
//
// The stimulus has these parts:
//   - a directed opening: field extremes, stray and zero-count fragments, sends
//     that are cut short, drops at the exact fill boundary, and empty and full
//     completion walks;
//   - random traffic that is mostly well-formed sends and completions, with some
//     truncated sends, oversized counts and loose fragments mixed in;
//   - a phase where the result side holds off for a long time, so the block
//     fills up and stalls its input;
//   - a last stretch with no idling on either side.
//
// Completions never walk into a slot that has not been written yet. The shadow
// remembers which slots hold a length, and the head index is chosen from that.
module tb_top;

    import trdm_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    // A completion walks at most 63 slots in the back end.
    // Waiting SETTLE_CYCLES once the pipe is empty covers the slowest walk.
    localparam int SETTLE_CYCLES = 100;

    // One predicted or observed result, one member per output port.
    typedef struct packed {
        status_t          status;
        logic [IDX_W-1:0] desc_index;
        logic [31:0]      cmd_word;
        logic [31:0]      length_word;
        logic             tail_update;
        logic [IDX_W-1:0] tail_index;
        logic [REC_W-1:0] reclaimed;
        logic [TOT_W-1:0] byte_total;
        logic [TOT_W-1:0] desc_total;
        logic [TOT_W-1:0] drop_total;
    } ring_result_t;

    // Shadow of the descriptor ring. It predicts the block's results and checks
    // them in order.
    class ring_tracker;
        logic [IDX_W-1:0] wr_idx;
        logic [IDX_W-1:0] rd_idx;
        logic [LEN_W-1:0] slot_len [RING_DEPTH];
        bit               slot_seen [RING_DEPTH];
        logic [TOT_W-1:0] bytes_done;
        logic [TOT_W-1:0] descs_done;
        logic [TOT_W-1:0] drops_done;
        logic [CNT_W-1:0] frags_owed;
        bit               in_drop;
        ring_result_t     due_results [$];
        int               mismatches;

        function new();
            int i;
            wr_idx     = '0;
            rd_idx     = '0;
            bytes_done = '0;
            descs_done = '0;
            drops_done = '0;
            frags_owed = '0;
            in_drop    = 1'b0;
            mismatches = 0;
            for (i = 0; i < RING_DEPTH; i++)
            begin
                slot_len[i]  = '0;
                slot_seen[i] = 1'b0;
            end
        endfunction

        function int occupancy();
            logic [IDX_W-1:0] occ;
            occ = wr_idx - rd_idx;
            return int'(occ);
        endfunction

        // Number of slots from the read index onward that already hold a length.
        // A completion may advance at most this far.
        function int walk_room();
            int               steps;
            logic [IDX_W-1:0] idx;
            steps = 0;
            idx   = rd_idx;
            while (steps < RING_DEPTH - 1 && slot_seen[idx])
            begin
                steps++;
                idx += 1'b1;
            end
            return steps;
        endfunction

        // Advances the shadow by one accepted transfer and queues its result.
        function void apply_request(desc_cmd_t r);
            ring_result_t     res;
            logic [IDX_W-1:0] occ;
            int unsigned      need;
            int unsigned      walked;
            logic [31:0]      cmd;
            res = '0;
            if (r.is_compl == MODE_COMPL)
            begin
                walked = 0;
                while (rd_idx != r.head)
                begin
                    bytes_done += TOT_W'(slot_len[rd_idx]);
                    descs_done += 1;
                    rd_idx     += 1'b1;
                    walked++;
                end
                res.status    = ST_COMPL;
                res.reclaimed = (walked > 63) ? REC_W'(63) : REC_W'(walked);
            end
            else
            begin
                // A new send opens on send_start, or on any fragment when none is open.
                if (r.start || frags_owed == 0)
                begin
                    need       = (r.start && r.count != 0) ? r.count : 1;
                    occ        = wr_idx - rd_idx;
                    frags_owed = CNT_W'(need);
                    in_drop    = (occ + need >= RING_DEPTH);
                    if (in_drop)
                        drops_done += 1;
                end
                frags_owed -= 1'b1;
                if (in_drop)
                    res.status = ST_DROPPED;
                else
                begin
                    cmd = {16'h0000, r.length} | CMD_DTYPE_DATA | CMD_FCS;
                    if (r.sop)
                        cmd |= CMD_FS;
                    if (r.eop)
                        cmd |= CMD_LS | CMD_IOC;
                    slot_len[wr_idx]  = r.length;
                    slot_seen[wr_idx] = 1'b1;
                    res.status        = ST_WRITTEN;
                    res.desc_index    = wr_idx;
                    res.cmd_word      = cmd;
                    res.length_word   = {r.length, 16'h0000};
                    wr_idx           += 1'b1;
                    if (frags_owed == 0)
                    begin
                        res.tail_update = 1'b1;
                        res.tail_index  = wr_idx;
                    end
                end
            end
            res.byte_total = bytes_done;
            res.desc_total = descs_done;
            res.drop_total = drops_done;
            due_results.push_back(res);
        endfunction

        function string show(ring_result_t r);
            return $sformatf("st=%0d idx=%0d cmd=%h len=%h tail=%0b/%0d rec=%0d bytes=%h descs=%h drops=%h",
                r.status, r.desc_index, r.cmd_word, r.length_word, r.tail_update,
                r.tail_index, r.reclaimed, r.byte_total, r.desc_total, r.drop_total);
        endfunction

        function void match_result(ring_result_t got);
            ring_result_t want;
            if (due_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with nothing pending: %s", show(got));
                return;
            end
            want = due_results.pop_front();
            if (got.status !== want.status || got.desc_index !== want.desc_index ||
                got.cmd_word !== want.cmd_word || got.length_word !== want.length_word ||
                got.tail_update !== want.tail_update || got.tail_index !== want.tail_index ||
                got.reclaimed !== want.reclaimed || got.byte_total !== want.byte_total ||
                got.desc_total !== want.desc_total || got.drop_total !== want.drop_total)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("result mismatch at %0t", $realtime);
                    $display("  expected %s", show(want));
                    $display("  actual   %s", show(got));
                end
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        mode;
    logic [15:0] frag_length;
    logic        sop_flag;
    logic        eop_flag;
    logic        send_start;
    logic [6:0]  send_fragments;
    logic [5:0]  head_index;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [5:0]  desc_index;
    logic [31:0] cmd_word;
    logic [31:0] length_word;
    logic        tail_update;
    logic [5:0]  tail_index;
    logic [5:0]  reclaimed;
    logic [31:0] byte_total;
    logic [31:0] desc_total;
    logic [31:0] drop_total;

    ring_tracker  book;
    ring_result_t observed;
    int           cycles;

    // The main flow and the receiver process share these flags.
    bit no_idle;    // the sender offers back to back
    bit quiet_rx;   // the receiver never stalls
    bit hold_req;   // asks the receiver for one long hold-off
    bit hold_on;    // the receiver is inside that hold-off

    tx_descriptor_ring_manager u_top
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .frag_length    (frag_length),
        .sop_flag       (sop_flag),
        .eop_flag       (eop_flag),
        .send_start     (send_start),
        .send_fragments (send_fragments),
        .head_index     (head_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .desc_index     (desc_index),
        .cmd_word       (cmd_word),
        .length_word    (length_word),
        .tail_update    (tail_update),
        .tail_index     (tail_index),
        .reclaimed      (reclaimed),
        .byte_total     (byte_total),
        .desc_total     (desc_total),
        .drop_total     (drop_total)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Results are sampled at the rising edge. At that point the stall value that
    // is read is the same one the block sees for this transfer.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            observed.status      = status_t'(status);
            observed.desc_index  = desc_index;
            observed.cmd_word    = cmd_word;
            observed.length_word = length_word;
            observed.tail_update = tail_update;
            observed.tail_index  = tail_index;
            observed.reclaimed   = reclaimed;
            observed.byte_total  = byte_total;
            observed.desc_total  = desc_total;
            observed.drop_total  = drop_total;
            book.match_result(observed);
        end
    end

    // Receiver: random stall bursts, stretches with no stalls, and the long
    // hold-off on request. Each pass makes one assignment and then lets time
    // pass, so out_stall never gets two updates in one step.
    initial
    begin
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1'b1;
                hold_on = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_on  = 1'b0;
                hold_req = 1'b0;
            end
            else if (quiet_rx || $urandom_range(0, 2) != 0)
            begin
                out_stall <= 1'b0;
                repeat (quiet_rx ? 1 : $urandom_range(1, 40)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
        end
    end

    // Watchdog for a hung handshake.
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [15:0] rand_len();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 16'h0000;
        if (pick == 1)
            return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    // Offers one transfer and returns at the edge that accepts it. valid stays
    // high on return, so a following call can present its item with no gap.
    // Before the item, the sender may idle for a random burst.
    task automatic push_request(input desc_cmd_t r);
        if (!no_idle && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        mode           <= r.is_compl;
        frag_length    <= r.length;
        sop_flag       <= r.sop;
        eop_flag       <= r.eop;
        send_start     <= r.start;
        send_fragments <= r.count;
        head_index     <= r.head;
        in_valid       <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        book.apply_request(r);
    endtask

    // The head index is ignored for a fragment, so it gets a random value.
    task automatic push_frag(input logic [15:0] len, input logic sop, input logic eop,
                             input logic start, input logic [6:0] count);
        desc_cmd_t r;
        r.is_compl = MODE_FRAG;
        r.length   = len;
        r.sop      = sop;
        r.eop      = eop;
        r.start    = start;
        r.count    = count;
        r.head     = IDX_W'($urandom_range(0, RING_DEPTH - 1));
        push_request(r);
    endtask

    // For a completion the fragment fields are ignored, so they get random values.
    task automatic push_compl(input logic [IDX_W-1:0] head);
        desc_cmd_t r;
        r.is_compl = MODE_COMPL;
        r.length   = rand_len();
        r.sop      = 1'($urandom_range(0, 1));
        r.eop      = 1'($urandom_range(0, 1));
        r.start    = 1'($urandom_range(0, 1));
        r.count    = CNT_W'($urandom_range(0, 127));
        r.head     = head;
        push_request(r);
    endtask

    // Sends n_frags fragments of a send that announces count_field fragments.
    // When the two differ, the send is left open and the next send cuts it.
    task automatic send_packet(input int n_frags, input int count_field);
        int i;
        for (i = 0; i < n_frags; i++)
            push_frag(rand_len(), i == 0, i == n_frags - 1, i == 0, CNT_W'(count_field));
    endtask

    // Stops offering and waits until every predicted result has been checked.
    task automatic drain();
        in_valid <= 1'b0;
        while (book.due_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_traffic(input int n);
        int done_items;
        int pick;
        int cnt;
        int part;
        int room;
        done_items = 0;
        while (done_items < n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 22)
            begin
                // Completion. It usually reclaims part of the backlog. Now and then
                // it runs past the write index, into slots that were written on an
                // earlier lap.
                room = book.walk_room();
                if ($urandom_range(0, 4) == 0)
                    part = $urandom_range(0, room);
                else
                    part = $urandom_range(0, (book.occupancy() < room) ? book.occupancy() : room);
                push_compl(book.rd_idx + IDX_W'(part));
                done_items++;
            end
            else if (pick < 84)
            begin
                // Well-formed send. A few large ones push the ring toward full.
                cnt = ($urandom_range(0, 11) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 6);
                send_packet(cnt, cnt);
                done_items += cnt;
            end
            else if (pick < 90)
            begin
                // Truncated send: fewer fragments than announced.
                cnt  = $urandom_range(2, 8);
                part = $urandom_range(1, cnt - 1);
                send_packet(part, cnt);
                done_items += part;
            end
            else if (pick < 94)
            begin
                // The count can never fit the ring, so the send is dropped.
                part = $urandom_range(1, 3);
                send_packet(part, $urandom_range(64, 127));
                done_items += part;
            end
            else
            begin
                // Loose fragment with random flags.
                push_frag(rand_len(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)),
                          ($urandom_range(0, 1) != 0) ? 7'd0 : CNT_W'($urandom_range(0, 127)));
                done_items++;
            end
        end
    endtask

    initial
    begin
        book     = new();
        no_idle  = 1'b0;
        quiet_rx = 1'b0;
        hold_req = 1'b0;
        hold_on  = 1'b0;

        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        mode           <= MODE_FRAG;
        frag_length    <= '0;
        sop_flag       <= 1'b0;
        eop_flag       <= 1'b0;
        send_start     <= 1'b0;
        send_fragments <= '0;
        head_index     <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A zero fragment count means one fragment. The length is zero and both
        // SOP and EOP are set.
        push_frag(16'h0000, 1'b1, 1'b1, 1'b1, 7'd0);
        // A stray fragment without send_start is a send of its own. The
        // length is at its maximum.
        push_frag(16'hFFFF, 1'b0, 1'b0, 1'b0, 7'd5);
        // A three-fragment send is cut after two fragments by a new send.
        // The old send gets no tail.
        push_frag(16'h1234, 1'b1, 1'b0, 1'b1, 7'd3);
        push_frag(16'h0040, 1'b0, 1'b0, 1'b0, 7'd0);
        push_frag(16'h8001, 1'b1, 1'b0, 1'b1, 7'd2);
        push_frag(16'h7FFE, 1'b0, 1'b1, 1'b0, 7'd0);
        // A partial completion, then the rest, then one that reclaims nothing.
        push_compl(book.wr_idx - 2'd2);
        push_compl(book.wr_idx);
        push_compl(book.rd_idx);
        // A count equal to the ring depth is dropped on every fragment. A new
        // send with the largest count cuts it and is dropped as well.
        push_frag(16'h0100, 1'b1, 1'b0, 1'b1, 7'd64);
        push_frag(16'h0101, 1'b0, 1'b0, 1'b0, 7'd0);
        push_frag(16'h0102, 1'b0, 1'b1, 1'b0, 7'd0);
        push_frag(16'h0200, 1'b1, 1'b1, 1'b1, 7'd127);
        // A new single-fragment send cuts the dropped one and is written.
        push_frag(16'h0300, 1'b1, 1'b1, 1'b1, 7'd1);
        push_frag(16'hABCD, 1'b0, 1'b1, 1'b0, 7'd0);
        // Exact fill boundary: occupancy plus count equal to the depth drops.
        // One less fits, and that send is then cut short.
        push_frag(16'h0400, 1'b1, 1'b0, 1'b1, CNT_W'(RING_DEPTH - book.occupancy()));
        push_frag(16'h0401, 1'b1, 1'b0, 1'b1, CNT_W'(RING_DEPTH - 1 - book.occupancy()));
        push_frag(16'h0402, 1'b0, 1'b0, 1'b0, 7'd0);
        push_frag(16'h0403, 1'b1, 1'b1, 1'b1, 7'd1);
        push_compl(book.wr_idx);
        drain();

        random_traffic(170);

        // The receiver holds off while the sender keeps offering, so the block
        // fills up and stalls its input.
        drain();
        hold_req = 1'b1;
        while (!hold_on)
            @(posedge clk);
        no_idle = 1'b1;
        random_traffic(48);
        no_idle = 1'b0;
        drain();

        random_traffic(140);

        // The last stretch runs at full rate on both sides.
        no_idle  = 1'b1;
        quiet_rx = 1'b1;
        random_traffic(80);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (book.mismatches == 0 && book.due_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
